// ===== rtl/core/stq_pkg.sv =====
package stq_pkg;

  localparam int unsigned DepthDefault     = 16;
  localparam int unsigned IdWidthDefault   = 16;
  localparam int unsigned TimeWidthDefault = 48;

  localparam int unsigned ModeW    = 2;
  localparam int unsigned AmountW  = 32;
  localparam int unsigned UnitW    = 2;
  localparam int unsigned EventW   = 16;
  localparam int unsigned TargetW  = 8;
  localparam int unsigned IdOutW   = 16;
  localparam int unsigned KindW    = 2;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned NumUnits = 4;
  localparam int unsigned MaxFires = 16;
  localparam int unsigned PaddrW   = 4;

  localparam logic [ModeW-1:0] ModeSet    = 2'd0;
  localparam logic [ModeW-1:0] ModeCancel = 2'd1;
  localparam logic [ModeW-1:0] ModeTick   = 2'd2;

  localparam logic [KindW-1:0] KindSetOk   = 2'd0;
  localparam logic [KindW-1:0] KindSetFull = 2'd1;
  localparam logic [KindW-1:0] KindCancel  = 2'd2;
  localparam logic [KindW-1:0] KindExpiry  = 2'd3;

  // Datapath operations requested by the controller.
  typedef enum logic [3:0] {
    OpNone    = 4'd0,
    OpLatch   = 4'd1,
    OpMul     = 4'd2,
    OpAlloc   = 4'd3,
    OpInsStep = 4'd4,
    OpInsDone = 4'd5,
    OpCanStep = 4'd6,
    OpTickInc = 4'd7,
    OpPopStep = 4'd8,
    OpRespond = 4'd9,
    OpFull    = 4'd10,
    OpCanResp = 4'd11,
    OpFetch   = 4'd12
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } stq_cmd_t;

  typedef struct packed {
    logic full;        // no free entry
    logic walk_end;    // insert walk reached its spot
    logic can_end;     // cancel search finished
    logic pop_due;     // head exists and is due
    logic pop_live;    // due head is alive
    logic fires_max;   // expiry budget spent
  } stq_sts_t;

endpackage

// ===== rtl/core/stq_if.sv =====
interface stq_in_if;
  import stq_pkg::*;
  logic               valid;
  logic               ready;
  logic [ModeW-1:0]   mode;
  logic [AmountW-1:0] delay_amount;
  logic [UnitW-1:0]   delay_unit;
  logic [EventW-1:0]  event_code;
  logic [TargetW-1:0] target_machine;
  logic [IdOutW-1:0]  cancel_id;
  modport source (output valid, mode, delay_amount, delay_unit, event_code,
                  target_machine, cancel_id, input ready);
  modport sink (input valid, mode, delay_amount, delay_unit, event_code,
                target_machine, cancel_id, output ready);
endinterface

interface stq_out_if;
  import stq_pkg::*;
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [IdOutW-1:0]  timer_id;
  logic [EventW-1:0]  fired_event;
  logic [TargetW-1:0] fired_target;
  logic               found;
  logic               last;
  modport source (output valid, kind, timer_id, fired_event, fired_target, found,
                  last, input ready);
  modport sink (input valid, kind, timer_id, fired_event, fired_target, found,
                last, output ready);
endinterface

// ===== rtl/core/sorted_timeout_queue_top.sv =====
// Timer queue of DEPTH entries kept as a deadline-sorted linked list with a
// free list. One item is handled at a time. A set scales the delay, takes a
// free entry and walks the list to its spot; a set that finds no free entry
// is refused; a cancel walks the list for its id; a tick advances time and
// pops due entries, giving one result per live expiry; an unused mode gives
// no result. The list walk of a set or a cancel goes one linked entry a
// cycle. Results leave through a registered output; the block takes no item
// until the last result of the current one has been delivered, so output
// stalls hold up the next item.
module sorted_timeout_queue_top
  import stq_pkg::*;
#(
  parameter int unsigned DEPTH      = DepthDefault,
  parameter int unsigned ID_WIDTH   = IdWidthDefault,
  parameter int unsigned TIME_WIDTH = TimeWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  stq_in_if.sink            in_if,
  stq_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [NumUnits-1:0][ScaleW-1:0] scale_q;
  stq_cmd_t cmd;
  stq_sts_t sts;
  logic     wr_en;
  logic [UnitW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[UnitW+1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign prdata  = (paddr[1:0] == 2'b00) ? {16'd0, scale_q[reg_idx]} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumUnits; i++) scale_q[i] <= ScaleW'(1);
    end else if (wr_en) begin
      scale_q[reg_idx] <= pwdata[ScaleW-1:0];
    end
  end

  stq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_mode_i   (in_if.mode),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_last_o  (out_if.last),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  stq_dp #(
    .DEPTH      (DEPTH),
    .ID_WIDTH   (ID_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (in_if.mode),
    .amount_i       (in_if.delay_amount),
    .unit_i         (in_if.delay_unit),
    .event_i        (in_if.event_code),
    .target_i       (in_if.target_machine),
    .cancel_id_i    (in_if.cancel_id),
    .scale_i        (scale_q),
    .kind_o         (out_if.kind),
    .timer_id_o     (out_if.timer_id),
    .fired_event_o  (out_if.fired_event),
    .fired_target_o (out_if.fired_target),
    .found_o        (out_if.found)
  );

endmodule

// ===== rtl/core/stq_ctrl.sv =====
module stq_ctrl
  import stq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ModeW-1:0] in_mode_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_last_o,
  output stq_cmd_t         cmd_o,
  input  stq_sts_t         sts_i
);

  typedef enum logic [10:0] {
    StIdle   = 11'b00000000001,
    StMul    = 11'b00000000010,
    StAlloc  = 11'b00000000100,
    StIns    = 11'b00000001000,
    StCan    = 11'b00000010000,
    StTick   = 11'b00000100000,
    StPop    = 11'b00001000000,
    StOut    = 11'b00010000000,
    StPopOut = 11'b00100000000,
    StFetch  = 11'b01000000000,
    StDecide = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   last_q, last_d;
  logic   pend_q, pend_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut) || (state_q == StPopOut);
  assign out_last_o  = last_q;

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    pend_d  = pend_q;
    cmd_o.op = OpNone;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.op = OpLatch;
          last_d = 1'b1;
          case (in_mode_i)
            ModeSet:    state_d = StMul;
            ModeCancel: state_d = StCan;
            ModeTick:   state_d = StTick;
            default:    state_d = StIdle;
          endcase
        end
      end
      StMul: begin
        cmd_o.op = OpMul;
        state_d = StAlloc;
      end
      StAlloc: begin
        if (sts_i.full) begin
          cmd_o.op = OpFull;
          state_d = StOut;
        end else begin
          cmd_o.op = OpAlloc;
          state_d = StIns;
        end
      end
      StIns: begin
        if (sts_i.walk_end) begin
          cmd_o.op = OpInsDone;
          state_d = StOut;
        end else begin
          cmd_o.op = OpInsStep;
        end
      end
      StCan: begin
        if (sts_i.can_end) begin
          cmd_o.op = OpCanResp;
          state_d = StOut;
        end else begin
          cmd_o.op = OpCanStep;
        end
      end
      StTick: begin
        cmd_o.op = OpTickInc;
        state_d = StFetch;
      end
      StFetch: begin
        cmd_o.op = OpFetch;
        state_d = StDecide;
      end
      StDecide: begin
        // A pending expiry result is shown once we know whether another follows.
        if (!sts_i.pop_due || sts_i.fires_max) begin
          if (pend_q) begin
            state_d = StPopOut;
            last_d = 1'b1;
          end else begin
            state_d = StIdle;
          end
        end else begin
          state_d = StPop;
        end
      end
      StPop: begin
        if (sts_i.pop_live) begin
          if (pend_q) begin
            // Another expiry follows, so the held one is not the last.
            state_d = StPopOut;
            last_d = 1'b0;
          end else begin
            cmd_o.op = OpRespond;
            pend_d = 1'b1;
            state_d = StFetch;
          end
        end else begin
          cmd_o.op = OpPopStep;
          state_d = StFetch;
        end
      end
      StPopOut: begin
        if (out_ready_i) begin
          pend_d = 1'b0;
          state_d = last_q ? StIdle : StPop;
        end
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      last_q  <= 1'b1;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      pend_q  <= pend_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("accepting while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");

endmodule

// ===== rtl/core/stq_dp.sv =====
module stq_dp
  import stq_pkg::*;
#(
  parameter int unsigned DEPTH      = DepthDefault,
  parameter int unsigned ID_WIDTH   = IdWidthDefault,
  parameter int unsigned TIME_WIDTH = TimeWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stq_cmd_t                      cmd_i,
  output stq_sts_t                      sts_o,
  input  logic [ModeW-1:0]              mode_i,
  input  logic [AmountW-1:0]            amount_i,
  input  logic [UnitW-1:0]              unit_i,
  input  logic [EventW-1:0]             event_i,
  input  logic [TargetW-1:0]            target_i,
  input  logic [IdOutW-1:0]             cancel_id_i,
  input  logic [NumUnits-1:0][ScaleW-1:0] scale_i,
  output logic [KindW-1:0]              kind_o,
  output logic [IdOutW-1:0]             timer_id_o,
  output logic [EventW-1:0]             fired_event_o,
  output logic [TargetW-1:0]            fired_target_o,
  output logic                          found_o
);

  localparam int unsigned PtrW  = $clog2(DEPTH + 1);
  localparam int unsigned IdxW  = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned FireW = $clog2(MaxFires + 1);
  localparam int unsigned ProdW = AmountW + ScaleW;
  localparam int unsigned CmpW  = (ID_WIDTH > IdOutW) ? ID_WIDTH : IdOutW;
  localparam logic [PtrW-1:0] Nil = PtrW'(DEPTH);
  localparam logic [TIME_WIDTH-1:0] TMax = '1;

  logic [TIME_WIDTH-1:0] dl_mem [DEPTH];
  logic [ID_WIDTH-1:0]   id_mem [DEPTH];
  logic [EventW-1:0]     ev_mem [DEPTH];
  logic [TargetW-1:0]    tg_mem [DEPTH];
  logic [PtrW-1:0]       link_q [DEPTH];
  logic [DEPTH-1:0]      alive_q;

  logic [TIME_WIDTH-1:0] now_q;
  logic [PtrW-1:0]       head_q, free_q, pos_q, prev_q, cur_q;
  logic [CntW-1:0]       used_q;
  logic [ID_WIDTH-1:0]   nid_q;
  logic [CntW-1:0]       steps_q;
  logic [FireW-1:0]      fires_q;
  logic [TIME_WIDTH-1:0] dl_q;
  logic [EventW-1:0]     ev_q;
  logic [TargetW-1:0]    tg_q;
  logic [IdOutW-1:0]     cid_q;
  logic [ProdW-1:0]      prod_q;
  logic [AmountW-1:0]    amount_i_q;
  logic [ScaleW-1:0]     scale_sel_q;

  logic [KindW-1:0]   kind_q;
  logic [IdOutW-1:0]  rid_q;
  logic [EventW-1:0]  rev_q;
  logic [TargetW-1:0] rtg_q;
  logic               rfound_q;

  logic [IdxW-1:0] cur_idx, head_idx;
  logic            cur_ok, head_ok;
  logic [ProdW:0]  room;
  logic [TIME_WIDTH-1:0] sum_dl;
  logic [TIME_WIDTH:0]   wide_sum;

  assign cur_idx  = cur_q[IdxW-1:0];
  assign head_idx = head_q[IdxW-1:0];
  assign cur_ok   = (cur_q < Nil) && (steps_q < CntW'(DEPTH));
  assign head_ok  = head_q < Nil;

  // Saturating now + product; the product may be wider or narrower than time.
  always_comb begin
    if (ProdW > TIME_WIDTH) begin
      room = '0;
      sum_dl = ((prod_q >> TIME_WIDTH) != '0) ? TMax : TIME_WIDTH'(prod_q);
      wide_sum = {1'b0, now_q} + {1'b0, sum_dl};
      if (wide_sum[TIME_WIDTH]) sum_dl = TMax;
      else sum_dl = wide_sum[TIME_WIDTH-1:0];
    end else begin
      room = '0;
      wide_sum = {1'b0, now_q} + (TIME_WIDTH+1)'(prod_q);
      sum_dl = wide_sum[TIME_WIDTH] ? TMax : wide_sum[TIME_WIDTH-1:0];
    end
  end

  assign sts_o.full     = (used_q >= CntW'(DEPTH)) || (free_q >= Nil);
  assign sts_o.walk_end = !cur_ok || (dl_mem[cur_idx] > dl_q);
  assign sts_o.can_end  = !cur_ok || (alive_q[cur_idx] &&
                          (CmpW'(id_mem[cur_idx]) == CmpW'(cid_q)));
  assign sts_o.pop_due  = head_ok && (steps_q < CntW'(DEPTH)) &&
                          (dl_mem[head_idx] <= now_q);
  assign sts_o.pop_live = alive_q[head_idx];
  assign sts_o.fires_max = fires_q >= FireW'(MaxFires);

  assign kind_o         = kind_q;
  assign timer_id_o     = rid_q;
  assign fired_event_o  = rev_q;
  assign fired_target_o = rtg_q;
  assign found_o        = rfound_q;

  // Entry payload stores and request latches, no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpAlloc) begin
      dl_mem[free_q[IdxW-1:0]] <= sum_dl;
      id_mem[free_q[IdxW-1:0]] <= nid_q;
      ev_mem[free_q[IdxW-1:0]] <= ev_q;
      tg_mem[free_q[IdxW-1:0]] <= tg_q;
    end
    if (cmd_i.op == OpLatch) begin
      dl_q  <= '0;
      ev_q  <= event_i;
      tg_q  <= target_i;
      cid_q <= cancel_id_i;
    end
    if (cmd_i.op == OpMul) prod_q <= amount_i_q * scale_sel_q;
    if (cmd_i.op == OpAlloc) dl_q <= sum_dl;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpLatch) begin
      amount_i_q  <= amount_i;
      scale_sel_q <= scale_i[unit_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) link_q[i] <= PtrW'(i + 1);
      alive_q  <= '0;
      now_q    <= '0;
      head_q   <= Nil;
      free_q   <= '0;
      used_q   <= '0;
      nid_q    <= '0;
      pos_q    <= Nil;
      prev_q   <= Nil;
      cur_q    <= Nil;
      steps_q  <= '0;
      fires_q  <= '0;
      kind_q   <= KindSetOk;
      rid_q    <= '0;
      rev_q    <= '0;
      rtg_q    <= '0;
      rfound_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OpLatch: begin
          cur_q   <= head_q;
          prev_q  <= Nil;
          steps_q <= '0;
          fires_q <= '0;
        end
        OpAlloc: begin
          pos_q  <= free_q;
          free_q <= link_q[free_q[IdxW-1:0]];
          alive_q[free_q[IdxW-1:0]] <= 1'b1;
          nid_q  <= nid_q + 1'b1;
          rid_q  <= IdOutW'(nid_q);
        end
        OpInsStep: begin
          prev_q  <= cur_q;
          cur_q   <= link_q[cur_idx];
          steps_q <= steps_q + 1'b1;
        end
        OpInsDone: begin
          if (prev_q >= Nil) head_q <= pos_q;
          else link_q[prev_q[IdxW-1:0]] <= pos_q;
          link_q[pos_q[IdxW-1:0]] <= (cur_q >= Nil) ? Nil : cur_q;
          used_q <= used_q + 1'b1;
          kind_q <= KindSetOk;
          rev_q <= '0;
          rtg_q <= '0;
          rfound_q <= 1'b0;
        end
        OpFull: begin
          kind_q <= KindSetFull;
          rid_q <= '0;
          rev_q <= '0;
          rtg_q <= '0;
          rfound_q <= 1'b0;
        end
        OpCanStep: begin
          cur_q   <= link_q[cur_idx];
          steps_q <= steps_q + 1'b1;
        end
        OpCanResp: begin
          kind_q <= KindCancel;
          rid_q  <= cid_q;
          rev_q  <= '0;
          rtg_q  <= '0;
          rfound_q <= cur_ok;
          if (cur_ok) alive_q[cur_idx] <= 1'b0;
        end
        OpTickInc: begin
          if (now_q != TMax) now_q <= now_q + 1'b1;
        end
        OpRespond: begin
          // The expiry is held in the result registers while the head is freed.
          kind_q <= KindExpiry;
          rid_q  <= IdOutW'(id_mem[head_idx]);
          rev_q  <= ev_mem[head_idx];
          rtg_q  <= tg_mem[head_idx];
          rfound_q <= 1'b0;
          fires_q <= fires_q + 1'b1;
          head_q <= (link_q[head_idx] >= Nil) ? Nil : link_q[head_idx];
          alive_q[head_idx] <= 1'b0;
          link_q[head_idx] <= free_q;
          free_q <= head_q;
          if (used_q != '0) used_q <= used_q - 1'b1;
          steps_q <= steps_q + 1'b1;
        end
        OpPopStep: begin
          head_q <= (link_q[head_idx] >= Nil) ? Nil : link_q[head_idx];
          alive_q[head_idx] <= 1'b0;
          link_q[head_idx] <= free_q;
          free_q <= head_q;
          if (used_q != '0) used_q <= used_q - 1'b1;
          steps_q <= steps_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  logic unused_mode;
  assign unused_mode = ^{mode_i, room};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(DEPTH))
    else $error("used count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OpAlloc) |=> (used_q == $past(used_q)))
    else $error("count moved during alloc");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OpRespond) |-> alive_q[head_idx])
    else $error("expiry of dead entry");

endmodule
